>>> src/dq_pkg.sv
package dq_pkg;

  // defaults for the top-level parameters
  localparam int CAPACITY_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  // command field width
  localparam int KIND_W = 3;

  // command codes, codes above query mean query
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_FRONT  = 3'd0,
    KIND_ADD_BACK   = 3'd1,
    KIND_TAKE_FRONT = 3'd2,
    KIND_TAKE_BACK  = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

endpackage

>>> src/double_ended_queue_top.sv
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// command   | in_valid / in_ready  | kind, push_value
// result    | out_valid / out_ready| popped_value, popped_valid, front_value,
//           |                      | back_value, ends_valid, entry_count,
//           |                      | is_empty, overflow
//
// pushes, queries, empty pops and pops of the last word finish without a refill read
// other pops also pass through the fill state: the new front or back word is read back from the
// slot ram, whose read port is registered
// rst is synchronous: the queue comes up empty, with no clearing pass over the ram
// a result waits in the output register while the next command is worked on;
// a second finished result waits in the controller and holds off further commands
module double_ended_queue_top #(
  parameter int CAPACITY  = dq_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF,
  localparam int PTR_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dq_pkg::KIND_W-1:0]   kind,
  input  logic signed [WORD_BITS-1:0] push_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] popped_value,
  output logic                        popped_valid,
  output logic signed [WORD_BITS-1:0] front_value,
  output logic signed [WORD_BITS-1:0] back_value,
  output logic                        ends_valid,
  output logic [CNT_W-1:0]            entry_count,
  output logic                        is_empty,
  output logic                        overflow
);

  // result handoff from the controller
  logic                        res_valid;
  logic                        res_ready;
  logic signed [WORD_BITS-1:0] res_popped_value;
  logic                        res_popped_valid;
  logic signed [WORD_BITS-1:0] res_front;
  logic signed [WORD_BITS-1:0] res_back;
  logic [CNT_W-1:0]            res_count;
  logic                        res_overflow;

  // slot ram port
  logic                        mem_wr_en;
  logic [PTR_W-1:0]            mem_wr_addr;
  logic [WORD_BITS-1:0]        mem_wr_data;
  logic                        mem_rd_en;
  logic [PTR_W-1:0]            mem_rd_addr;
  logic [WORD_BITS-1:0]        mem_rd_data;

  dq_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .push_value       (push_value),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_popped_value (res_popped_value),
    .res_popped_valid (res_popped_valid),
    .res_front        (res_front),
    .res_back         (res_back),
    .res_count        (res_count),
    .res_overflow     (res_overflow),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

  // slot storage, one word per ring position
  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register takes a result whenever it is empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      popped_value <= res_popped_value;
      popped_valid <= res_popped_valid;
      front_value  <= res_front;
      back_value   <= res_back;
      ends_valid   <= (res_count != '0);
      entry_count  <= res_count;
      is_empty     <= (res_count == '0);
      overflow     <= res_overflow;
    end
  end

endmodule

>>> src/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/dq_ctrl.sv
module dq_ctrl #(
  parameter int CAPACITY  = dq_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF,
  localparam int PTR_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // command side
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dq_pkg::KIND_W-1:0]   kind,
  input  logic signed [WORD_BITS-1:0] push_value,
  // result side
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [WORD_BITS-1:0] res_popped_value,
  output logic                        res_popped_valid,
  output logic signed [WORD_BITS-1:0] res_front,
  output logic signed [WORD_BITS-1:0] res_back,
  output logic [CNT_W-1:0]            res_count,
  output logic                        res_overflow,
  // slot memory
  output logic                        mem_wr_en,
  output logic [PTR_W-1:0]            mem_wr_addr,
  output logic [WORD_BITS-1:0]        mem_wr_data,
  output logic                        mem_rd_en,
  output logic [PTR_W-1:0]            mem_rd_addr,
  input  logic [WORD_BITS-1:0]        mem_rd_data
);

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? LAST_SLOT : p - PTR_W'(1);
    return r;
  endfunction

  state_t                      st;
  logic [PTR_W-1:0]            head, head_next;
  logic [PTR_W-1:0]            tail, tail_next;
  logic [CNT_W-1:0]            count, count_next;
  logic signed [WORD_BITS-1:0] front, front_next;
  logic signed [WORD_BITS-1:0] back, back_next;
  logic signed [WORD_BITS-1:0] popped, popped_next;
  logic                        popped_ok, popped_ok_next;
  logic                        over, over_next;
  logic                        fill_front, fill_front_next;
  logic                        accept, done, go_fill;
  logic                        is_full, is_none;

  assign in_ready = (st == S_IDLE) && (!res_valid || res_ready);
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == FULL_CNT);
  assign is_none  = (count == '0);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_next      = front;
    back_next       = back;
    popped_next     = popped;
    popped_ok_next  = popped_ok;
    over_next       = over;
    fill_front_next = fill_front;
    done            = 1'b0;
    go_fill         = 1'b0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = tail;
    mem_wr_data     = push_value;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = ring_next(head);
    if (st == S_IDLE && accept) begin
      popped_next    = '0;
      popped_ok_next = 1'b0;
      over_next      = 1'b0;
      done           = 1'b1;
      case (dq_pkg::kind_t'(kind))
        dq_pkg::KIND_ADD_FRONT: begin
          if (is_full) begin
            over_next = 1'b1;
          end else begin
            head_next   = ring_prev(head);
            mem_wr_en   = 1'b1;
            mem_wr_addr = ring_prev(head);
            front_next  = push_value;
            if (is_none) begin
              back_next = push_value;
            end
            count_next = count + ONE_CNT;
          end
        end
        dq_pkg::KIND_ADD_BACK: begin
          if (is_full) begin
            over_next = 1'b1;
          end else begin
            tail_next   = ring_next(tail);
            mem_wr_en   = 1'b1;
            mem_wr_addr = tail;
            back_next   = push_value;
            if (is_none) begin
              front_next = push_value;
            end
            count_next = count + ONE_CNT;
          end
        end
        dq_pkg::KIND_TAKE_FRONT: begin
          if (!is_none) begin
            popped_next    = front;
            popped_ok_next = 1'b1;
            head_next      = ring_next(head);
            count_next     = count - ONE_CNT;
            if (count != ONE_CNT) begin
              // refetch the new front word
              mem_rd_en       = 1'b1;
              mem_rd_addr     = ring_next(head);
              fill_front_next = 1'b1;
              go_fill         = 1'b1;
              done            = 1'b0;
            end
          end
        end
        dq_pkg::KIND_TAKE_BACK: begin
          if (!is_none) begin
            popped_next    = back;
            popped_ok_next = 1'b1;
            tail_next      = ring_prev(tail);
            count_next     = count - ONE_CNT;
            if (count != ONE_CNT) begin
              // refetch the new back word
              mem_rd_en       = 1'b1;
              mem_rd_addr     = ring_prev(ring_prev(tail));
              fill_front_next = 1'b0;
              go_fill         = 1'b1;
              done            = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (st == S_FILL) begin
      done = 1'b1;
      if (fill_front) begin
        front_next = mem_rd_data;
      end else begin
        back_next = mem_rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (go_fill) begin
            st <= S_FILL;
          end
        end
        S_FILL: begin
          st <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (done) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    front      <= front_next;
    back       <= back_next;
    popped     <= popped_next;
    popped_ok  <= popped_ok_next;
    over       <= over_next;
    fill_front <= fill_front_next;
  end

  assign res_popped_value = popped;
  assign res_popped_valid = popped_ok;
  assign res_front        = is_none ? '0 : front;
  assign res_back         = is_none ? '0 : back;
  assign res_count        = count;
  assign res_overflow     = over;

  // count never passes the capacity
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("entry count above capacity");

  // a pop on a non-empty queue removes exactly one word
  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_none &&
     (kind == dq_pkg::KIND_TAKE_FRONT || kind == dq_pkg::KIND_TAKE_BACK))
    |=> count == $past(count) - ONE_CNT)
    else $error("pop did not decrement count");

  // the refill read always posts a result
  assert property (@(posedge clk) disable iff (rst) (st == S_FILL) |=> res_valid)
    else $error("refill did not post a result");

  // overflow is flagged only when the queue is full
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_overflow) |-> is_full)
    else $error("overflow flagged on a queue with room");

endmodule
